[rtl/ccc_pkg.sv]
// package for the coil combiner: widths, constants, cordic angle table, fsm states
// no dependencies
`default_nettype none
package ccc_pkg;
    localparam int MaxRowWidth = 1024;
    localparam int MaxCoils    = 32;
    localparam int CordicSteps = 15;
    localparam int CordicW     = 30;
    localparam int InvGainQ16  = 39797;

    localparam logic [0:0] CFG_ROW_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_COIL_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ATAN, ST_ACC, ST_SQRT, ST_ROT, ST_FIN, ST_OUT
    } ccc_state_t;

    typedef struct packed {
        logic load_atan;
        logic step;
        logic acc;
        logic load_sqrt;
        logic sqrt_step;
        logic load_rot;
        logic finish;
        logic clear;
    } ccc_cmd_t;

    function automatic logic [15:0] atan_entry(input logic [3:0] i);
        logic [15:0] r;
        begin
            case (i)
                4'd0:  r = 16'd8192;
                4'd1:  r = 16'd4836;
                4'd2:  r = 16'd2555;
                4'd3:  r = 16'd1297;
                4'd4:  r = 16'd651;
                4'd5:  r = 16'd326;
                4'd6:  r = 16'd163;
                4'd7:  r = 16'd81;
                4'd8:  r = 16'd41;
                4'd9:  r = 16'd20;
                4'd10: r = 16'd10;
                4'd11: r = 16'd5;
                4'd12: r = 16'd3;
                4'd13: r = 16'd1;
                4'd14: r = 16'd1;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

[rtl/ccc_stream_if.sv]
// valid/ready stream interface with a generic payload
// depends on nothing
`default_nettype none
interface ccc_stream_if #(parameter int Width = 32);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/ccc_datapath.sv]
// datapath: shared cordic, energy and phase accumulators, iterative sqrt, output scaling
// depends on ccc_pkg
`default_nettype none
module ccc_datapath
    import ccc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ccc_cmd_t           cmd,
    input  wire logic [3:0]         iter,
    input  wire logic signed [15:0] in_re,
    input  wire logic signed [15:0] in_im,
    output logic signed [18:0]      out_re,
    output logic signed [18:0]      out_im
);
    logic signed [CordicW-1:0] x_reg, y_reg;
    logic signed [17:0]        z_reg;
    logic [31:0]               nrm_reg;
    logic [36:0]               energy_reg;
    logic [15:0]               phase_reg;
    logic [38:0]               sq_v_reg;
    logic [38:0]               sq_bit_reg;
    logic [38:0]               sq_root_reg;
    logic [15:0]               ang;
    logic [36:0]               energy_sum;
    logic [38:0]               sum_rb;
    logic signed [16:0]        t17;

    // one cordic step (vectoring in atan, rotation otherwise)
    logic signed [CordicW-1:0] xs, ys;
    logic                      dir_pos;
    logic [15:0]               tab;
    always_comb
    begin
        xs      = x_reg >>> iter;
        ys      = y_reg >>> iter;
        tab     = atan_entry(iter);
        dir_pos = ~z_reg[17];
    end

    // output scaling by the inverse cordic gain, rounded to nearest
    logic signed [CordicW+16:0] prod_re, prod_im;
    logic signed [CordicW+16:0] r_re, r_im;
    always_comb
    begin
        prod_re = (CordicW+17)'(x_reg) * (CordicW+17)'(signed'(18'(InvGainQ16)))
                  + (CordicW+17)'(signed'(25'(1 << 23)));
        prod_im = (CordicW+17)'(y_reg) * (CordicW+17)'(signed'(18'(InvGainQ16)))
                  + (CordicW+17)'(signed'(25'(1 << 23)));
        r_re = prod_re >>> 24;
        r_im = prod_im >>> 24;
    end

    assign ang        = z_reg[15:0];
    assign t17        = signed'({phase_reg[15], phase_reg});
    assign sum_rb     = sq_root_reg + sq_bit_reg;
    // energy including the sample accumulated this cycle
    assign energy_sum = energy_reg + 37'(nrm_reg);

    // pixel accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            phase_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            energy_reg <= '0;
            phase_reg  <= '0;
        end
        else if (cmd.acc)
        begin
            energy_reg <= energy_sum;
            phase_reg  <= phase_reg + 16'(nrm_reg[15:0] * ang);
        end
    end

    // cordic, sqrt and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_atan)
        begin
            nrm_reg <= 32'(in_re) * 32'(in_re) + 32'(in_im) * 32'(in_im);
            if (in_re[15])
            begin
                x_reg <= -(CordicW'(in_re) <<< 8);
                y_reg <= -(CordicW'(in_im) <<< 8);
                z_reg <= 18'sd32768;
            end
            else
            begin
                x_reg <= CordicW'(in_re) <<< 8;
                y_reg <= CordicW'(in_im) <<< 8;
                z_reg <= '0;
            end
        end
        else if (cmd.load_sqrt)
        begin
            sq_v_reg    <= 39'(cmd.acc ? energy_sum : energy_reg);
            sq_bit_reg  <= 39'(1) << 38;
            sq_root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_v_reg >= sum_rb)
            begin
                sq_v_reg    <= sq_v_reg - sum_rb;
                sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
            end
            else
                sq_root_reg <= sq_root_reg >> 1;
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        else if (cmd.load_rot)
        begin
            y_reg <= '0;
            if (t17 > 17'sd16384)
            begin
                x_reg <= -(CordicW'(sq_root_reg[18:0]) <<< 8);
                z_reg <= 18'(t17) - 18'sd32768;
            end
            else if (t17 < -17'sd16384)
            begin
                x_reg <= -(CordicW'(sq_root_reg[18:0]) <<< 8);
                z_reg <= 18'(t17) + 18'sd32768;
            end
            else
            begin
                x_reg <= CordicW'(sq_root_reg[18:0]) <<< 8;
                z_reg <= 18'(t17);
            end
        end
        else if (cmd.step)
        begin
            // finish together with step selects vectoring, driven by the sign of y
            if (cmd.finish)
            begin
                if (~y_reg[CordicW-1])
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + 18'(tab);
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - 18'(tab);
                end
            end
            else if (dir_pos)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - 18'(tab);
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + 18'(tab);
            end
        end
        else if (cmd.finish)
        begin
            out_re <= (r_re > 47'sd262143) ? 19'sd262143 :
                      (r_re < -47'sd262144) ? -19'sd262144 : 19'(r_re);
            out_im <= (r_im > 47'sd262143) ? 19'sd262143 :
                      (r_im < -47'sd262144) ? -19'sd262144 : 19'(r_im);
        end
    end
endmodule
`default_nettype wire

[rtl/ccc_ctrl.sv]
// controller: counters, crop decision and sequencing of the shared cordic and sqrt
// depends on ccc_pkg
`default_nettype none
module ccc_ctrl
    import ccc_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = MaxRowWidth,
    parameter int MAX_COILS     = MaxCoils
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [10:0] row_width,
    input  wire logic [5:0]  coil_count,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             row_end,
    output ccc_cmd_t         cmd,
    output logic [3:0]       iter
);
    localparam int ColW = $clog2(MAX_ROW_WIDTH);
    localparam int ChW  = (MAX_COILS > 1) ? $clog2(MAX_COILS) : 1;

    ccc_state_t     state_reg, state_next;
    logic [3:0]     iter_reg, iter_next;
    logic [ColW-1:0] col_reg, col_next;
    logic [ChW-1:0] ch_reg, ch_next;
    logic           kept_reg, kept_next;
    logic           last_reg, last_next;
    logic           rend_reg, rend_next;
    logic           oend_reg, oend_next;
    logic           ov_reg, ov_next;

    logic [12:0] w, half, start, coils;
    always_comb
    begin
        w     = (13'(row_width) > 13'(MAX_ROW_WIDTH)) ? 13'(MAX_ROW_WIDTH) : 13'(row_width);
        half  = w >> 1;
        start = (w - half) >> 1;
        coils = (coil_count == '0) ? 13'd1 : 13'(coil_count);
        if (coils > 13'(MAX_COILS))
            coils = 13'(MAX_COILS);
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
    assign row_end   = oend_reg;
    assign iter      = iter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
            col_reg   <= '0;
            ch_reg    <= '0;
            kept_reg  <= 1'b0;
            last_reg  <= 1'b0;
            rend_reg  <= 1'b0;
            oend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            col_reg   <= col_next;
            ch_reg    <= ch_next;
            kept_reg  <= kept_next;
            last_reg  <= last_next;
            rend_reg  <= rend_next;
            oend_reg  <= oend_next;
            ov_reg    <= ov_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        col_next   = col_reg;
        ch_next    = ch_reg;
        kept_next  = kept_reg;
        last_next  = last_reg;
        rend_next  = rend_reg;
        oend_next  = oend_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    kept_next = (13'(col_reg) >= start) && (13'(col_reg) < start + half);
                    last_next = (13'(ch_reg) + 13'd1 >= coils);
                    rend_next = (13'(col_reg) + 13'd1 == start + half);
                    cmd.load_atan = 1'b1;
                    iter_next  = '0;
                    state_next = ST_ATAN;
                end
            end
            ST_ATAN:
            begin
                cmd.step   = 1'b1;
                cmd.finish = 1'b1;
                iter_next  = iter_reg + 4'd1;
                if (iter_reg == 4'(CordicSteps - 1))
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (kept_reg)
                    cmd.acc = 1'b1;
                if (!last_reg)
                begin
                    ch_next    = ch_reg + ChW'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    ch_next  = '0;
                    col_next = (13'(col_reg) + 13'd1 >= w) ? '0 : col_reg + ColW'(1);
                    if (kept_reg)
                    begin
                        cmd.load_sqrt = 1'b1;
                        iter_next     = '0;
                        state_next    = ST_SQRT;
                    end
                    else
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                iter_next     = iter_reg + 4'd1;
                if (iter_reg == 4'd15)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // four more sqrt steps then rotation load
                if (iter_reg < 4'd4)
                begin
                    cmd.sqrt_step = 1'b1;
                    iter_next     = iter_reg + 4'd1;
                end
                else
                begin
                    cmd.load_rot = 1'b1;
                    iter_next    = '0;
                    state_next   = ST_ROT;
                end
            end
            ST_ROT:
            begin
                cmd.step  = 1'b1;
                iter_next = iter_reg + 4'd1;
                if (iter_reg == 4'(CordicSteps - 1))
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // load the output register once it is free or being taken
                if (!ov_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    cmd.clear  = 1'b1;
                    ov_next    = 1'b1;
                    oend_next  = rend_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[rtl/crop_coil_combine.sv]
// crop_coil_combine: root-sum-of-squares coil combiner with centre crop
// one sample: load, 15 cordic atan2 iterations, then accumulate
// last channel of a kept pixel adds 20 sqrt steps, a load, 15 rotation steps and scaling;
// a waiting pixel holds the next pixel only at its scaling step
// reset clears counters and sums; registers return to row_width 256, coil_count 8
// depends on ccc_pkg, ccc_stream_if, ccc_ctrl, ccc_datapath
`default_nettype none
module crop_coil_combine
    import ccc_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = MaxRowWidth,
    parameter int MAX_COILS     = MaxCoils
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    ccc_stream_if.sink       samples,
    ccc_stream_if.source     pixels
);
    logic [10:0] row_width_reg;
    logic [5:0]  coil_count_reg;
    ccc_cmd_t    cmd;
    logic [3:0]  iter;
    logic        row_end;
    logic signed [18:0] pre, pim;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg  <= 11'd256;
            coil_count_reg <= 6'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROW_WIDTH:  row_width_reg  <= cfg_data;
                CFG_COIL_COUNT: coil_count_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    ccc_ctrl #(.MAX_ROW_WIDTH(MAX_ROW_WIDTH), .MAX_COILS(MAX_COILS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .row_width(row_width_reg), .coil_count(coil_count_reg),
        .in_valid(samples.valid), .in_ready(samples.ready),
        .out_valid(pixels.valid), .out_ready(pixels.ready),
        .row_end(row_end), .cmd(cmd), .iter(iter)
    );

    ccc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .iter(iter),
        .in_re(samples.data[15:0]), .in_im(samples.data[31:16]),
        .out_re(pre), .out_im(pim)
    );

    assign pixels.data = {row_end, pim, pre};
endmodule
`default_nettype wire
